// ===== src/pss_pkg.sv =====
package pss_pkg;

    localparam int MaxSegmentsDefault = 16;
    localparam logic [15:0] SegLenReset = 16'd256;

    localparam int DistSqW = 34;
    localparam int RootW = 17;

    localparam int InTdataW = 112;
    localparam int OutTdataW = 112;

    typedef struct packed {
        logic [15:0] rotation;
        logic [15:0] tilt;
        logic [31:0] stamp;
        logic [15:0] pressure;
        logic [15:0] y;
        logic [15:0] x;
    } point_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SQ    = 7'b0000010,
        ST_ROOT  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_FIELD = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_LAST  = 7'b1000000
    } state_t;

endpackage

// ===== src/pss_lerp_div.sv =====
module pss_lerp_div
    import pss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [52:0] num,
    input  logic        [7:0]  den,
    output logic               done,
    output logic signed [45:0] quo
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [52:0] q_reg, q_next;
    logic [8:0]  rem_reg, rem_next;
    logic [8:0]  den_reg, den_next;
    logic [9:0]  trial;
    logic [52:0] mag;

    assign mag = num[52] ? 53'(-num) : 53'(num);
    assign trial = {rem_reg, q_reg[52]} - {1'b0, den_reg};

    always_comb begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        done = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 6'd53;
            neg_next = num[52];
            q_next = num[52] ? 53'(mag + 53'({den, 1'b0}) - 53'd1) : mag;
            rem_next = '0;
            den_next = {den, 1'b0};
        end else if (busy_reg) begin
            if (!trial[9]) begin
                rem_next = trial[8:0];
                q_next = {q_reg[51:0], 1'b1};
            end else begin
                rem_next = {rem_reg[7:0], q_reg[52]};
                q_next = {q_reg[51:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
        if (busy_reg && cnt_reg == 6'd1) begin
            done = 1'b1;
        end
    end

    assign quo = neg_reg ? -$signed(46'(q_next)) : $signed(46'(q_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        neg_reg <= neg_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// ===== src/polyline_segment_subdivider.sv =====
// Resamples a pen stroke: each accepted beat is a point, and when it lies
// further than segment_length from the previous point, n-1 interpolated
// beats (n = floor(distance/segment_length), at most MAX_SEGMENTS) precede
// the point itself. The block takes one point at a time. A point that starts
// a line, or one within segment_length, goes straight to the output, and the
// next point is taken only once that beat has left the output register. A
// subdivided point first runs the shift-subtract square root and the count
// division, then computes the six fields of each interpolated beat one after
// another on the shared 53-step serial divider before its own beat. Any stall
// on the output holds up these steps.
module polyline_segment_subdivider
    import pss_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // x, y, pressure, stamp, tilt, rotation from bit 0 up
    input  logic [InTdataW-1:0]  s_tdata,
    // first_point
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_x, out_y, out_pressure, out_stamp, out_tilt, out_rotation
    output logic [OutTdataW-1:0] m_tdata,
    // run_end
    output logic                 m_tlast,
    // capped
    output logic                 m_tuser
);

    localparam int NW = $clog2(MAX_SEGMENTS + 1);

    state_t      state_reg;
    logic [15:0] seglen_reg;
    logic        have_prev_reg;
    point_t      a_reg, b_reg, outp_reg, lerp_reg;
    logic        ovalid_reg, olast_reg, ocap_reg, cap_reg;
    logic [DistSqW-1:0] d2_reg, lim_reg;
    logic [DistSqW-1:0] rem_reg;
    logic [RootW-1:0]   root_reg;
    logic [5:0]  cnt_reg;
    logic [16:0] len_reg;
    logic [16:0] nq_reg;
    logic [16:0] nrem_reg;
    logic [NW-1:0] n_reg, j_reg;
    logic [2:0]  fld_reg;
    logic        dstart_reg, dbusy_reg;
    logic signed [16:0] dx, dy;
    logic signed [52:0] dnum;
    logic        ddone;
    logic signed [45:0] dquo;
    logic signed [32:0] fa, fb;
    logic [DistSqW-1:0] rtrial;
    logic [17:0] ntrial;
    logic        out_load;

    assign cfg_ready = state_reg == ST_IDLE;
    assign s_tready = state_reg == ST_IDLE && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = outp_reg;
    assign m_tlast = olast_reg;
    assign m_tuser = ocap_reg;

    assign out_load = (state_reg == ST_EMIT && !ovalid_reg)
                      || (state_reg == ST_LAST && (!ovalid_reg || m_tready));

    assign dx = 17'(signed'(b_reg.x)) - 17'(signed'(a_reg.x));
    assign dy = 17'(signed'(b_reg.y)) - 17'(signed'(a_reg.y));

    always_comb begin
        fa = '0;
        fb = '0;
        case (fld_reg)
            3'd0: begin fa = 33'(signed'(a_reg.x)); fb = 33'(signed'(b_reg.x)); end
            3'd1: begin fa = 33'(signed'(a_reg.y)); fb = 33'(signed'(b_reg.y)); end
            3'd2: begin fa = 33'(a_reg.pressure); fb = 33'(b_reg.pressure); end
            3'd3: begin fa = 33'(a_reg.stamp); fb = 33'(b_reg.stamp); end
            3'd4: begin fa = 33'(signed'(a_reg.tilt)); fb = 33'(signed'(b_reg.tilt)); end
            default: begin fa = 33'(a_reg.rotation); fb = 33'(b_reg.rotation); end
        endcase
    end

    // 2*(a*(n-j)+b*j)+n
    assign dnum = 53'(fa) * 53'(n_reg - j_reg) * 53'sd2 + 53'(fb) * 53'(j_reg) * 53'sd2
                  + 53'(n_reg);

    pss_lerp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dstart_reg),
        .num     (dnum),
        .den     (8'(n_reg)),
        .done    (ddone),
        .quo     (dquo)
    );

    assign rtrial = {rem_reg[DistSqW-3:0], d2_reg[DistSqW-1 -: 2]}
                    - {root_reg[RootW-2:0], 2'b01};
    assign ntrial = {nrem_reg, nq_reg[16]} - {1'b0, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seglen_reg <= SegLenReset;
            have_prev_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            dstart_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            a_reg <= '0;
        end else begin
            if (ovalid_reg && m_tready && !out_load) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) seglen_reg <= cfg_data;
                    if (s_tvalid && s_tready) begin
                        b_reg <= s_tdata;
                        have_prev_reg <= 1'b1;
                        cap_reg <= 1'b0;
                        if (s_tuser || !have_prev_reg) begin
                            state_reg <= ST_LAST;
                        end else begin
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    d2_reg <= DistSqW'(dx * dx) + DistSqW'(dy * dy);
                    lim_reg <= (seglen_reg == 16'd0) ? DistSqW'(1)
                               : DistSqW'(seglen_reg) * DistSqW'(seglen_reg);
                    len_reg <= (seglen_reg == 16'd0) ? 17'd1 : 17'(seglen_reg);
                    rem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg <= 6'd17;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (d2_reg <= lim_reg && cnt_reg == 6'd17) begin
                        state_reg <= ST_LAST;
                    end else begin
                        d2_reg <= {d2_reg[DistSqW-3:0], 2'b00};
                        if (!rtrial[DistSqW-1]) begin
                            rem_reg <= rtrial;
                            root_reg <= {root_reg[RootW-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[DistSqW-3:0], d2_reg[DistSqW-1 -: 2]};
                            root_reg <= {root_reg[RootW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1) begin
                            state_reg <= ST_DIV;
                            nrem_reg <= '0;
                            cnt_reg <= 6'd17;
                        end
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == 6'd17 && nrem_reg == '0 && !dbusy_reg) begin
                        nq_reg <= root_reg;
                        dbusy_reg <= 1'b1;
                    end else begin
                        if (!ntrial[17]) begin
                            nrem_reg <= ntrial[16:0];
                            nq_reg <= {nq_reg[15:0], 1'b1};
                        end else begin
                            nrem_reg <= {nrem_reg[15:0], nq_reg[16]};
                            nq_reg <= {nq_reg[15:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1) begin
                            dbusy_reg <= 1'b0;
                            state_reg <= ST_FIELD;
                            j_reg <= NW'(1);
                            fld_reg <= 3'd0;
                        end
                    end
                end
                ST_FIELD: begin
                    if (!dbusy_reg) begin
                        if (fld_reg == 3'd0 && j_reg == NW'(1) && !dstart_reg) begin
                            if (nq_reg > 17'(MAX_SEGMENTS)) begin
                                n_reg <= NW'(MAX_SEGMENTS);
                                cap_reg <= 1'b1;
                            end else begin
                                n_reg <= NW'(nq_reg);
                            end
                            if (nq_reg < 17'd2) state_reg <= ST_LAST;
                            else dbusy_reg <= 1'b1;
                            dstart_reg <= nq_reg >= 17'd2;
                        end else begin
                            dstart_reg <= 1'b0;
                        end
                    end else if (ddone) begin
                        case (fld_reg)
                            3'd0: lerp_reg.x <= 16'(dquo);
                            3'd1: lerp_reg.y <= 16'(dquo);
                            3'd2: lerp_reg.pressure <= 16'(dquo);
                            3'd3: lerp_reg.stamp <= 32'(dquo);
                            3'd4: lerp_reg.tilt <= 16'(dquo);
                            default: lerp_reg.rotation <= 16'(dquo);
                        endcase
                        if (fld_reg == 3'd5) begin
                            dbusy_reg <= 1'b0;
                            dstart_reg <= 1'b0;
                            state_reg <= ST_EMIT;
                        end else begin
                            fld_reg <= fld_reg + 3'd1;
                            dstart_reg <= 1'b1;
                        end
                    end else begin
                        dstart_reg <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!ovalid_reg) begin
                        ovalid_reg <= 1'b1;
                        outp_reg <= lerp_reg;
                        olast_reg <= 1'b0;
                        ocap_reg <= cap_reg;
                        fld_reg <= 3'd0;
                        if (j_reg + NW'(1) == n_reg) begin
                            state_reg <= ST_LAST;
                        end else begin
                            j_reg <= j_reg + NW'(1);
                            state_reg <= ST_FIELD;
                            dbusy_reg <= 1'b1;
                            dstart_reg <= 1'b1;
                        end
                    end
                end
                ST_LAST: begin
                    if (!ovalid_reg || m_tready) begin
                        ovalid_reg <= 1'b1;
                        outp_reg <= b_reg;
                        olast_reg <= 1'b1;
                        ocap_reg <= cap_reg;
                        a_reg <= b_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !ovalid_reg) else $error("input taken while a result waits");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !ovalid_reg) |=> m_tvalid && !m_tlast)
        else $error("interpolated beat missing");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule
